>>> design/sgd_pkg.sv
// Shared types, register indexes and defaults for the structured-light Gray decoder.
package sgd_pkg;

   // Parameter defaults
   localparam int MAX_CODE_BITS_DEF  = 12;
   localparam int INTENSITY_BITS_DEF = 8;

   // Configuration port geometry
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 13;

   // Fixed result geometry
   localparam int INDEX_BITS = 12;

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROW_CODE_BITS = 3'd0,
      CSR_COL_CODE_BITS = 3'd1,
      CSR_ROW_OFFSET    = 3'd2,
      CSR_COL_OFFSET    = 3'd3,
      CSR_PROJ_COLS     = 3'd4,
      CSR_PROJ_ROWS     = 3'd5,
      CSR_CONTRAST_MIN  = 3'd6
   } csr_index_type;

   // Configuration register set
   typedef struct packed {
      logic [3:0]  row_code_bits;
      logic [3:0]  col_code_bits;
      logic [10:0] row_offset;
      logic [10:0] col_offset;
      logic [12:0] proj_cols;
      logic [12:0] proj_rows;
      logic [7:0]  contrast_min;
   } cfg_type;

   // Reset values
   localparam cfg_type CFG_RESET = '{
      row_code_bits: 4'd0,
      col_code_bits: 4'd10,
      row_offset:    11'd0,
      col_offset:    11'd0,
      proj_cols:     13'd1024,
      proj_rows:     13'd768,
      contrast_min:  8'd32
   };

endpackage

>>> design/sgd_csr.sv
// Configuration register file of the structured-light Gray decoder.
module sgd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sgd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sgd_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output sgd_pkg::cfg_type                   cfg
);
   import sgd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register decode; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW_CODE_BITS: cfg_in.row_code_bits = csr_data[3:0];
            CSR_COL_CODE_BITS: cfg_in.col_code_bits = csr_data[3:0];
            CSR_ROW_OFFSET:    cfg_in.row_offset    = csr_data[10:0];
            CSR_COL_OFFSET:    cfg_in.col_offset    = csr_data[10:0];
            CSR_PROJ_COLS:     cfg_in.proj_cols     = csr_data[12:0];
            CSR_PROJ_ROWS:     cfg_in.proj_rows     = csr_data[12:0];
            CSR_CONTRAST_MIN:  cfg_in.contrast_min  = csr_data[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> design/structured_light_gray_decoder.sv
// A result is registered once the last plane sample leaves the input register.
// Throughput: one sample per cycle while no finished result waits on rsp_tready;
// a new sample can still enter the input register while a finished result waits.
// Each sample goes through one compare, one xor and one add.
// Reset (synchronous, active high) empties both registers, returns the pixel
// sequencer to idle and loads the configuration reset values.
module structured_light_gray_decoder #(
   parameter int MAX_CODE_BITS  = sgd_pkg::MAX_CODE_BITS_DEF,
   parameter int INTENSITY_BITS = sgd_pkg::INTENSITY_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // Sample stream
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((INTENSITY_BITS+7)/8)*8-1:0]      req_tdata,  // intensity, zero pad
   input  logic                                     req_tuser,  // pixel_start
   // Result stream
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [2*sgd_pkg::INDEX_BITS-1:0]         rsp_tdata,  // row_index, col_index
   output logic                                     rsp_tuser,  // pixel_valid
   // Configuration writes
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [sgd_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [sgd_pkg::CSR_DATA_BITS-1:0]        csr_data
);
   import sgd_pkg::*;

   localparam int IW  = INTENSITY_BITS;
   localparam int SW  = MAX_CODE_BITS;
   localparam int FPW = $clog2(2*MAX_CODE_BITS+3);
   localparam int DW  = ((SW > 13) ? SW : 13) + 1;

   cfg_type cfg;

   sgd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Input register
   logic          in_vld_ff;
   logic [IW-1:0] in_int_ff;
   logic          in_start_ff;

   // Pixel state
   logic [FPW-1:0] fp_ff,    fp_in;
   logic [IW-1:0]  white_ff, white_in;
   logic [IW-1:0]  thr_ff,   thr_in;
   logic           cok_ff,   cok_in;
   logic           bin_ff,   bin_in;
   logic [SW-1:0]  rsum_ff,  rsum_in;
   logic [SW-1:0]  csum_ff,  csum_in;

   // Result register
   logic                    out_vld_ff;
   logic [2*INDEX_BITS-1:0] out_data_ff, out_data_in;
   logic                    out_user_ff, out_user_in;

   logic adv;
   logic emit;

   // A sample moves on when the result slot is free or being emptied
   assign adv        = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || adv;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   // Per-sample step
   logic [FPW-1:0] nr, nc, total, j, k, n, sh;
   logic [IW:0]    wsum;
   logic [IW-1:0]  half, adiff;
   logic           bit_v, bin_new, is_row;
   logic [SW-1:0]  weight;
   logic [DW-1:0]  cdiff, rdiff;
   logic           ok;

   always_comb begin
      nr = (32'(cfg.row_code_bits) > MAX_CODE_BITS) ? FPW'(MAX_CODE_BITS)
                                                    : FPW'(cfg.row_code_bits);
      nc = (32'(cfg.col_code_bits) > MAX_CODE_BITS) ? FPW'(MAX_CODE_BITS)
                                                    : FPW'(cfg.col_code_bits);
      total = nr + nc;

      // Rounded mean of white and black, ties to even
      wsum  = {1'b0, white_ff} + {1'b0, in_int_ff};
      half  = wsum[IW:1];
      if (wsum[0] && half[0]) begin
         half = half + IW'(1);
      end
      adiff = (white_ff >= in_int_ff) ? (white_ff - in_int_ff) : (in_int_ff - white_ff);

      // Plane bit and Gray-to-binary accumulation
      j       = fp_ff - FPW'(2);
      is_row  = (j < nr);
      k       = is_row ? j : (j - nr);
      n       = is_row ? nr : nc;
      sh      = n - FPW'(1) - k;
      bit_v   = (in_int_ff >= thr_ff);
      bin_new = (k == '0) ? bit_v : (bin_ff ^ bit_v);
      weight  = SW'(1) << sh;

      fp_in    = fp_ff;
      white_in = white_ff;
      thr_in   = thr_ff;
      cok_in   = cok_ff;
      bin_in   = bin_ff;
      rsum_in  = rsum_ff;
      csum_in  = csum_ff;
      emit     = 1'b0;

      if (in_start_ff) begin
         white_in = in_int_ff;
         rsum_in  = '0;
         csum_in  = '0;
         bin_in   = 1'b0;
         cok_in   = 1'b0;
         fp_in    = FPW'(1);
      end else if (fp_ff == FPW'(1)) begin
         thr_in = half;
         cok_in = (adiff >= IW'(cfg.contrast_min));
         fp_in  = FPW'(2);
         if (total == '0) begin
            emit  = 1'b1;
            fp_in = '0;
         end
      end else if (fp_ff != '0) begin
         if (j >= total) begin
            // Plane count lowered under a running pixel
            fp_in = '0;
         end else begin
            bin_in = bin_new;
            if (bin_new && is_row) begin
               rsum_in = rsum_ff + weight;
            end
            if (bin_new && !is_row) begin
               csum_in = csum_ff + weight;
            end
            fp_in = fp_ff + FPW'(1);
            if (j + FPW'(1) == total) begin
               emit  = 1'b1;
               fp_in = '0;
            end
         end
      end

      // Range checks on the offset-corrected sums
      cdiff = DW'(csum_in) - DW'(cfg.col_offset);
      rdiff = DW'(rsum_in) - DW'(cfg.row_offset);
      ok = cok_in &&
           (DW'(csum_in) >= DW'(cfg.col_offset)) && (cdiff < DW'(cfg.proj_cols)) &&
           (DW'(rsum_in) >= DW'(cfg.row_offset)) && (rdiff < DW'(cfg.proj_rows));
      out_data_in = ok ? {rdiff[INDEX_BITS-1:0], cdiff[INDEX_BITS-1:0]} : '0;
      out_user_in = ok;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         fp_ff      <= '0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (adv && emit) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
         if (adv) begin
            fp_ff <= fp_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_int_ff   <= req_tdata[IW-1:0];
         in_start_ff <= req_tuser;
      end
      if (adv) begin
         white_ff <= white_in;
         thr_ff   <= thr_in;
         cok_ff   <= cok_in;
         bin_ff   <= bin_in;
         rsum_ff  <= rsum_in;
         csum_ff  <= csum_in;
      end
      if (adv && emit) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end

endmodule
